/* hdl/lsae_pkg.sv */
// lsae_pkg: shared constants, codes, types and the color wheel function
// of the led strip animation engine; no dependencies
package lsae_pkg;

  localparam int MAX_PIXELS = 128;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);

  localparam int CMD_W      = 2;
  localparam int MODE_IN_W  = 4;
  localparam int MODE_W     = 3;
  localparam int IDX_W      = 7;
  localparam int LEN_W      = 7;
  localparam int PHASE_W    = 8;
  localparam int SUB_W      = 2;
  localparam int CNT_W      = 16;
  localparam int COLOR_W    = 24;
  localparam int DELAY_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SELECT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  // spare code, changes no state and returns black
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LIGHT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CHASE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLASH   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WIPE    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RCHASE  = 3'd6;
  localparam logic [MODE_W-1:0] MODE_PARTY   = 3'd7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTY_PERIOD = 2'd1;

  localparam logic [LEN_W-1:0]   RST_STRIP_LENGTH = 7'd105;
  localparam logic [CNT_W-1:0]   RST_PARTY_PERIOD = 16'd315;
  localparam logic [DELAY_W-1:0] DELAY_SLOW       = 8'd30;
  localparam logic [DELAY_W-1:0] DELAY_FAST       = 8'd15;
  localparam logic [PHASE_W-1:0] FLASH_START      = 8'd60;
  localparam logic [PHASE_W-1:0] FLASH_TOP        = 8'd235;
  localparam logic [PHASE_W-1:0] FLASH_BOTTOM     = 8'd80;
  localparam logic [PHASE_W-1:0] FLASH_STEP       = 8'd20;

  localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;
  localparam logic [COLOR_W-1:0] COLOR_LIGHT = 24'h788080;
  localparam logic [COLOR_W-1:0] COLOR_RED   = 24'hFF0000;
  localparam logic [COLOR_W-1:0] COLOR_GREEN = 24'h00FF00;
  localparam logic [COLOR_W-1:0] COLOR_BLUE  = 24'h0000FF;

  typedef enum logic [2:0] {
    OP_FILL    = 3'd0,
    OP_CHASE   = 3'd1,
    OP_WIPE    = 3'd2,
    OP_RAINBOW = 3'd3,
    OP_RCHASE  = 3'd4
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic step;
    logic capture;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep;
    logic last;
  } dp_status_t;

  // color wheel, thirds of the hue circle
  function automatic logic [COLOR_W-1:0] wheel(input logic [7:0] p);
    logic [7:0] q;
    logic [7:0] t;
    begin
      if (p < 8'd85) begin
        q = p;
      end else if (p < 8'd170) begin
        q = p - 8'd85;
      end else begin
        q = p - 8'd170;
      end
      t = q + {q[6:0], 1'b0};
      if (p < 8'd85) begin
        wheel = {t, 8'd255 - t, 8'd0};
      end else if (p < 8'd170) begin
        wheel = {8'd255 - t, 8'd0, t};
      end else begin
        wheel = {8'd0, t, 8'd255 - t};
      end
    end
  endfunction

endpackage

/* hdl/lsae_ram.sv */
// lsae_ram: generic single write port ram with registered read
// no dependencies
module lsae_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/lsae_ctrl.sv */
// lsae_ctrl: item sequencer (idle, pixel sweep, finish) and result valid
// depends on lsae_pkg
module lsae_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  lsae_pkg::dp_status_t sts_i,
  output lsae_pkg::ctrl_cmd_t  cmd_o
);
  import lsae_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SWEEP = 3'b010,
    S_FIN   = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   stall;

  assign stall = (state_q != S_IDLE) || out_valid_q;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && out_stall_i;
    cmd_o.accept  = 1'b0;
    cmd_o.step    = 1'b0;
    cmd_o.capture = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !stall) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.sweep ? S_SWEEP : S_FIN;
        end
      end
      S_SWEEP: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.capture = 1'b1;
        out_valid_d   = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = stall;
  assign out_valid_o = out_valid_q;

endmodule

/* hdl/lsae_dp.sv */
// lsae_dp: animation state, config registers, pixel sweep writer and result registers
// depends on lsae_pkg and lsae_ram
module lsae_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lsae_pkg::ctrl_cmd_t                 cmd_i,
  output lsae_pkg::dp_status_t                sts_o,
  input  logic [lsae_pkg::CMD_W-1:0]          cmd_field_i,
  input  logic [lsae_pkg::MODE_IN_W-1:0]      mode_i,
  input  logic [lsae_pkg::IDX_W-1:0]          pixel_index_i,
  input  logic                                cfg_we_i,
  input  logic [lsae_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lsae_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic [lsae_pkg::COLOR_W-1:0]        pixel_color_o,
  output logic [lsae_pkg::DELAY_W-1:0]        frame_delay_ms_o,
  output logic [lsae_pkg::MODE_W-1:0]         active_mode_o
);
  import lsae_pkg::*;

  // animation state
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [SUB_W-1:0]   sub_q, sub_d;
  logic               ramp_q, ramp_d;
  logic [CNT_W-1:0]   pcount_q, pcount_d;
  logic [MODE_W-1:0]  psub_q, psub_d;
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic [LEN_W-1:0]   len_q;
  logic [CNT_W-1:0]   period_q;

  // sweep parameters
  op_e                sw_op_q, sw_op_d;
  logic [COLOR_W-1:0] sw_color_q, sw_color_d;
  logic [PHASE_W-1:0] sw_ph_q, sw_ph_d;
  logic [SUB_W-1:0]   sw_a_q, sw_a_d;
  logic [SUB_W-1:0]   sw_b_q, sw_b_d;
  logic [1:0]         m_old_q, m_new_q;
  logic [ADDR_W-1:0]  addr_q;
  logic               need_sweep;

  // read and result
  logic                  is_read_q;
  logic                  rd_ok_q;
  logic [MAX_PIXELS-1:0] vld_q;
  logic [ADDR_W-1:0]     raddr;
  logic [COLOR_W-1:0]    rdata;
  logic [COLOR_W-1:0]    color_q;

  // write port
  logic               we;
  logic [COLOR_W-1:0] wdata;

  function automatic logic [1:0] neg_mod3(input logic [1:0] p);
    case (p)
      2'd1:    neg_mod3 = 2'd2;
      2'd2:    neg_mod3 = 2'd1;
      default: neg_mod3 = 2'd0;
    endcase
  endfunction

  // next state for an accepted item
  always_comb begin
    logic [MODE_W-1:0]  em;
    logic [MODE_W-1:0]  sel;
    logic               start_en;
    logic [MODE_W-1:0]  start_sel;
    logic [PHASE_W-1:0] np;
    logic               flip;
    logic               r;
    logic [CNT_W-1:0]   cnt;
    logic [MODE_W-1:0]  nsub;
    mode_d     = mode_q;
    phase_d    = phase_q;
    sub_d      = sub_q;
    ramp_d     = ramp_q;
    pcount_d   = pcount_q;
    psub_d     = psub_q;
    delay_d    = delay_q;
    sw_op_d    = OP_FILL;
    sw_color_d = COLOR_BLACK;
    sw_ph_d    = phase_q;
    sw_a_d     = 2'd0;
    sw_b_d     = 2'd0;
    need_sweep = 1'b0;
    start_en   = 1'b0;
    start_sel  = MODE_OFF;
    em         = (mode_q == MODE_PARTY) ? psub_q : mode_q;
    sel        = (mode_i[3] == 1'b0) ? mode_i[MODE_W-1:0] : MODE_OFF;
    np         = phase_q + 8'd1;
    flip       = 1'b0;
    r          = ramp_q;
    cnt        = pcount_q;
    nsub       = psub_q;
    case (cmd_field_i)
      CMD_SELECT: begin
        mode_d    = sel;
        start_en  = 1'b1;
        start_sel = sel;
        if (sel == MODE_LIGHT) begin
          need_sweep = 1'b1;
          sw_op_d    = OP_FILL;
          sw_color_d = COLOR_LIGHT;
        end
      end
      CMD_FRAME: begin
        case (em)
          MODE_OFF: begin
            need_sweep = 1'b1;
            sw_op_d    = OP_FILL;
            sw_color_d = COLOR_BLACK;
          end
          MODE_CHASE: begin
            need_sweep = 1'b1;
            sw_op_d    = OP_CHASE;
            sw_a_d     = phase_q[SUB_W-1:0];
            phase_d    = (np >= 8'd3) ? 8'd0 : np;
            sw_b_d     = phase_d[SUB_W-1:0];
          end
          MODE_FLASH: begin
            need_sweep = 1'b1;
            sw_op_d    = OP_FILL;
            sw_color_d = {phase_q, 8'd0, phase_q};
            flip       = (ramp_q && phase_q > FLASH_TOP) ||
                         (!ramp_q && phase_q < FLASH_BOTTOM);
            r          = ramp_q ^ flip;
            ramp_d     = r;
            phase_d    = r ? phase_q + FLASH_STEP : phase_q - FLASH_STEP;
          end
          MODE_WIPE: begin
            need_sweep = 1'b1;
            sw_op_d    = OP_WIPE;
            sw_ph_d    = phase_q;
            sw_b_d     = sub_q;
            if (np > {1'b0, len_q}) begin
              phase_d = 8'd0;
              case (sub_q)
                2'd0:    sub_d = 2'd1;
                2'd1:    sub_d = 2'd2;
                2'd2:    sub_d = 2'd0;
                default: sub_d = 2'd1;
              endcase
            end else begin
              phase_d = np;
            end
          end
          MODE_RAINBOW: begin
            need_sweep = 1'b1;
            sw_op_d    = OP_RAINBOW;
            sw_ph_d    = phase_q;
            phase_d    = np;
          end
          MODE_RCHASE: begin
            need_sweep = 1'b1;
            sw_op_d    = OP_RCHASE;
            phase_d    = np;
            sw_ph_d    = np;
            sw_a_d     = sub_q;
            sub_d      = sub_q + 2'd1;
            sw_b_d     = sub_d;
          end
          default: begin
          end
        endcase
        if (mode_q == MODE_PARTY) begin
          cnt = pcount_q + 16'd1;
          if (cnt == period_q) begin
            cnt  = '0;
            nsub = psub_q + 3'd1;
            if (nsub < MODE_CHASE || nsub > MODE_RCHASE) begin
              nsub = MODE_CHASE;
            end
            psub_d    = nsub;
            start_en  = 1'b1;
            start_sel = nsub;
          end
          pcount_d = cnt;
        end
      end
      default: begin
      end
    endcase
    // start actions of the chosen mode
    if (start_en) begin
      case (start_sel)
        MODE_CHASE, MODE_RAINBOW: begin
          delay_d = DELAY_SLOW;
          phase_d = '0;
        end
        MODE_FLASH: begin
          delay_d = DELAY_SLOW;
          phase_d = FLASH_START;
          ramp_d  = 1'b1;
        end
        MODE_WIPE: begin
          delay_d = DELAY_FAST;
          phase_d = '0;
          sub_d   = '0;
        end
        MODE_RCHASE: begin
          delay_d = DELAY_SLOW;
          phase_d = '0;
          sub_d   = '0;
        end
        MODE_PARTY: begin
          pcount_d = '0;
          psub_d   = MODE_CHASE;
          delay_d  = DELAY_SLOW;
          phase_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // per address pattern of the running sweep
  always_comb begin
    int  a;
    int  dn;
    int  d_o;
    int  h;
    logic in_new;
    logic in_old;
    a      = int'(addr_q);
    dn     = a - int'(sw_b_q);
    d_o    = a - int'(sw_a_q);
    h      = dn + int'(sw_ph_q);
    if (h >= 255) begin
      h = h - 255;
    end
    in_new = 1'b0;
    in_old = 1'b0;
    we     = 1'b0;
    wdata  = COLOR_BLACK;
    case (sw_op_q)
      OP_FILL: begin
        we    = a < int'(len_q);
        wdata = sw_color_q;
      end
      OP_CHASE: begin
        in_new = (dn >= 0) && (dn < int'(len_q)) && (m_new_q == 2'd0);
        in_old = (d_o >= 0) && (d_o < int'(len_q)) && (m_old_q == 2'd0);
        we     = in_new || in_old;
        wdata  = in_new ? COLOR_BLUE : COLOR_BLACK;
      end
      OP_WIPE: begin
        we = (a == int'(sw_ph_q)) && (sw_b_q != 2'd3);
        case (sw_b_q)
          2'd0:    wdata = COLOR_RED;
          2'd1:    wdata = COLOR_GREEN;
          default: wdata = COLOR_BLUE;
        endcase
      end
      OP_RAINBOW: begin
        we    = a < int'(len_q);
        wdata = wheel(8'(a + int'(sw_ph_q)));
      end
      OP_RCHASE: begin
        // every fourth pixel: low two bits of the offset are zero
        in_new = (dn >= 0) && (dn < int'(len_q)) && (dn[1:0] == 2'd0);
        in_old = (d_o >= 0) && (d_o < int'(len_q)) && (d_o[1:0] == 2'd0);
        we     = in_new || in_old;
        wdata  = in_new ? wheel(8'(h)) : COLOR_BLACK;
      end
      default: begin
      end
    endcase
    we = we && cmd_i.step;
  end

  assign sts_o.sweep = need_sweep;
  assign sts_o.last  = (addr_q == ADDR_W'(MAX_PIXELS - 1));

  assign raddr = ADDR_W'(pixel_index_i);

  lsae_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(MAX_PIXELS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(addr_q),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_OFF;
      phase_q   <= '0;
      sub_q     <= '0;
      ramp_q    <= 1'b0;
      pcount_q  <= '0;
      psub_q    <= MODE_CHASE;
      delay_q   <= DELAY_SLOW;
      len_q     <= RST_STRIP_LENGTH;
      period_q  <= RST_PARTY_PERIOD;
      vld_q     <= '0;
      sw_op_q   <= OP_FILL;
      addr_q    <= '0;
      m_old_q   <= '0;
      m_new_q   <= '0;
      is_read_q <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == REG_STRIP_LENGTH) begin
        len_q <= cfg_data_i[LEN_W-1:0];
      end
      if (cfg_we_i && cfg_index_i == REG_PARTY_PERIOD) begin
        period_q <= cfg_data_i[CNT_W-1:0];
      end
      if (cmd_i.accept) begin
        mode_q    <= mode_d;
        phase_q   <= phase_d;
        sub_q     <= sub_d;
        ramp_q    <= ramp_d;
        pcount_q  <= pcount_d;
        psub_q    <= psub_d;
        delay_q   <= delay_d;
        sw_op_q   <= sw_op_d;
        addr_q    <= '0;
        m_old_q   <= neg_mod3(sw_a_d);
        m_new_q   <= neg_mod3(sw_b_d);
        is_read_q <= (cmd_field_i == CMD_READ);
        rd_ok_q   <= (int'(pixel_index_i) < MAX_PIXELS) && vld_q[raddr];
      end
      if (cmd_i.step) begin
        addr_q  <= addr_q + ADDR_W'(1);
        m_old_q <= (m_old_q == 2'd2) ? 2'd0 : m_old_q + 2'd1;
        m_new_q <= (m_new_q == 2'd2) ? 2'd0 : m_new_q + 2'd1;
      end
      if (we) begin
        vld_q[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sw_color_q <= sw_color_d;
      sw_ph_q    <= sw_ph_d;
      sw_a_q     <= sw_a_d;
      sw_b_q     <= sw_b_d;
    end
    if (cmd_i.capture) begin
      color_q <= (is_read_q && rd_ok_q) ? rdata : COLOR_BLACK;
    end
  end

  assign pixel_color_o    = color_q;
  assign frame_delay_ms_o = delay_q;
  assign active_mode_o    = mode_q;

endmodule

/* hdl/led_strip_animation_engine_top.sv */
// led_strip_animation_engine_top: top level of the led strip animation engine
// depends on lsae_pkg, lsae_ctrl, lsae_dp, lsae_ram
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    cmd_i, mode_i, pixel_index_i
//   out      output     out_valid_o / out_stall_i  pixel_color_o, frame_delay_ms_o,
//                                                  active_mode_o
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one item at a time; a frame tick outside light mode or a light select sweeps every
// pixel address, one ram write a cycle, from address 0 up to MAX_PIXELS - 1
// a read, a plain select or an unused command skips the sweep (registered ram read)
// reset clears the control state and the per-pixel valid bits at once: no clear pass
// in_stall_o stays high while an item is in work or its result beat waits to be taken
// cfg writes are always ready and are meant for idle periods
module led_strip_animation_engine_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lsae_pkg::CMD_W-1:0]          cmd_i,
  input  logic [lsae_pkg::MODE_IN_W-1:0]      mode_i,
  input  logic [lsae_pkg::IDX_W-1:0]          pixel_index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lsae_pkg::COLOR_W-1:0]        pixel_color_o,
  output logic [lsae_pkg::DELAY_W-1:0]        frame_delay_ms_o,
  output logic [lsae_pkg::MODE_W-1:0]         active_mode_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lsae_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lsae_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import lsae_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       in_acc;
  logic       out_acc;

  // config port never back-pressures
  assign cfg_ready_o = 1'b1;

  // sequencer: owns the handshakes and the result valid
  lsae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: mode state, pixel memory, sweep writer, result registers
  lsae_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cmd_field_i     (cmd_i),
    .mode_i          (mode_i),
    .pixel_index_i   (pixel_index_i),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pixel_color_o   (pixel_color_o),
    .frame_delay_ms_o(frame_delay_ms_o),
    .active_mode_o   (active_mode_o)
  );

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // an item is never taken while a result beat is pending
  a_no_accept_with_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !out_valid_o)
    else $error("input beat accepted while result pending");

  // once an item is taken the block is busy on the next cycle
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("block not busy after accept");

  // exactly one result per item: no second beat right after one is taken
  a_single_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |=> !out_valid_o)
    else $error("repeated result beat");

  // the controller only steps the sweep or captures when no item is being taken
  a_cmd_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd.accept, cmd.step, cmd.capture}) <= 1)
    else $error("controller commands overlap");

endmodule
